### hdl/thick_line_pixel_generator_unit_assert.svh
// Assertion macros for the thick line pixel generator.
// Included by the top level; no other dependencies.
`ifndef THICK_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define THICK_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TLPG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle implication");
`define TLPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle implication");
`else
`define TLPG_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define TLPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/tlpg_pkg.sv
// Shared types and constants for the thick line pixel generator.
// No dependencies; used by tlpg_walker and the top level.
package tlpg_pkg;

   localparam int COORD_BITS_DEF = 13;
   localparam int PEN_BITS_DEF   = 8;
   localparam int CFG_BITS       = 13;
   localparam int CFG_IDX_BITS   = 2;
   localparam int ADDR_BITS      = 24;
   localparam int COLOR_BITS     = 32;
   localparam int RSP_TDATA_BITS = ((ADDR_BITS + COLOR_BITS + 7) / 8) * 8;

   localparam logic [CFG_BITS-1:0] ROW_STRIDE_RST   = CFG_BITS'(1080);
   localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(1080);
   localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(2280);

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   typedef enum logic [CFG_IDX_BITS-1:0] {
      REG_ROW_STRIDE   = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_idx_type;

   // One candidate pixel, already clipped: row/col/color are zero when not written.
   typedef struct packed {
      logic [CFG_BITS-1:0]   row;
      logic [CFG_BITS-1:0]   col;
      logic                  we;
      logic                  done;
      logic [COLOR_BITS-1:0] color;
   } pix_type;

endpackage

### hdl/thick_line_pixel_generator_unit.sv
// Top level of the thick line pixel generator: ports, pixel stage, address stage.
// Depends on tlpg_pkg, tlpg_walker and thick_line_pixel_generator_unit_assert.svh.
//
//   channel  dir  handshake              contents
//   req      in   req_tvalid/tready      start item (tuser 0) or advance tick (tuser 1)
//   rsp      out  rsp_tvalid/tready      one candidate pixel per advance tick
//   csr      in   csr_we                 row_stride, frame_width, frame_height
//
// One advance beat per clock while rsp does not stall; its pixel is registered in the pixel
// stage and then in the rsp output register before it can leave.
// The walker updates the whole line and stamp state in one register step per beat,
// and the address multiply sits in the following stage. Start beats give no pixel.
// Reset puts the block idle and loads the default frame geometry.
// A stalled rsp holds the output register and, once the pixel stage is full, req.
module thick_line_pixel_generator_unit #(
   parameter int COORD_BITS = tlpg_pkg::COORD_BITS_DEF,
   parameter int PEN_BITS   = tlpg_pkg::PEN_BITS_DEF,
   localparam int REQ_BITS  = 4 * COORD_BITS + PEN_BITS + tlpg_pkg::COLOR_BITS,
   localparam int REQ_TDATA_BITS = ((REQ_BITS + 7) / 8) * 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // start_x, start_y, end_x, end_y, pen_size, line_color, zero pad
   input  logic [REQ_TDATA_BITS-1:0]               req_tdata,
   // kind
   input  logic                                    req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // pixel_address, pixel_value
   output logic [tlpg_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   // write_enable
   output logic                                    rsp_tuser,
   output logic                                    rsp_tlast,
   input  logic                                    csr_we,
   input  logic [tlpg_pkg::CFG_IDX_BITS-1:0]       csr_index,
   input  logic [tlpg_pkg::CFG_BITS-1:0]           csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int CW = tlpg_pkg::CFG_BITS;

   logic [CW-1:0] stride_ff, stride_in, width_ff, width_in, height_ff, height_in;

   logic req_fire, load, step, out_free, s1_free, s1_adv;
   logic s1_valid_ff, s1_valid_in;
   tlpg_pkg::pix_type pix, s1_pix_ff, s1_pix_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [tlpg_pkg::RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_we_ff, rsp_we_in, rsp_done_ff, rsp_done_in;
   logic [2*CW:0] addr_full;

   // Configuration registers
   always_comb begin
      stride_in = stride_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlpg_pkg::REG_ROW_STRIDE:   stride_in = csr_wdata;
            tlpg_pkg::REG_FRAME_WIDTH:  width_in  = csr_wdata;
            tlpg_pkg::REG_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      s1_adv     = s1_valid_ff && out_free;
      s1_free    = !s1_valid_ff || out_free;
      req_tready = s1_free;
      req_fire   = req_tvalid && req_tready;
      load       = req_fire && (req_tuser == tlpg_pkg::KIND_START);
      step       = req_fire && (req_tuser == tlpg_pkg::KIND_ADVANCE);
   end

   tlpg_walker #(
      .COORD_BITS (COORD_BITS),
      .PEN_BITS   (PEN_BITS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .step         (step),
      .start_x      (req_tdata[CB-1:0]),
      .start_y      (req_tdata[2*CB-1:CB]),
      .end_x        (req_tdata[3*CB-1:2*CB]),
      .end_y        (req_tdata[4*CB-1:3*CB]),
      .pen_size     (req_tdata[4*CB+PEN_BITS-1:4*CB]),
      .line_color   (req_tdata[REQ_BITS-1:4*CB+PEN_BITS]),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .pix          (pix)
   );

   // Pixel stage: hold the clipped pixel of an advance beat
   always_comb begin
      s1_pix_in   = step ? pix : s1_pix_ff;
      s1_valid_in = step ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   // Address stage: row * stride + column, wrapped to the address width
   always_comb begin
      addr_full    = (2*CW + 1)'(s1_pix_ff.row * stride_ff) + (2*CW + 1)'(s1_pix_ff.col);
      rsp_data_in  = rsp_data_ff;
      rsp_we_in    = rsp_we_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_data_in  = {s1_pix_ff.color, addr_full[tlpg_pkg::ADDR_BITS-1:0]};
         rsp_we_in    = s1_pix_ff.we;
         rsp_done_in  = s1_pix_ff.done;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff    <= tlpg_pkg::ROW_STRIDE_RST;
         width_ff     <= tlpg_pkg::FRAME_WIDTH_RST;
         height_ff    <= tlpg_pkg::FRAME_HEIGHT_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stride_ff    <= stride_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_pix_ff   <= s1_pix_in;
      rsp_data_ff <= rsp_data_in;
      rsp_we_ff   <= rsp_we_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_done_ff;

`include "thick_line_pixel_generator_unit_assert.svh"

   `TLPG_ASSERT_NEXT(a_advance_fills_stage, clock, reset, step, s1_valid_ff)
   `TLPG_ASSERT_IMPLY(a_unwritten_zero_data, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

endmodule

### hdl/tlpg_walker.sv
// Line state of the thick line pixel generator: Bresenham walk plus square stamp.
// Produces the current candidate pixel; depends on tlpg_pkg.
module tlpg_walker #(
   parameter int COORD_BITS = tlpg_pkg::COORD_BITS_DEF,
   parameter int PEN_BITS   = tlpg_pkg::PEN_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic                                 step,
   input  logic signed [COORD_BITS-1:0]         start_x,
   input  logic signed [COORD_BITS-1:0]         start_y,
   input  logic signed [COORD_BITS-1:0]         end_x,
   input  logic signed [COORD_BITS-1:0]         end_y,
   input  logic [PEN_BITS-1:0]                  pen_size,
   input  logic [tlpg_pkg::COLOR_BITS-1:0]      line_color,
   input  logic [tlpg_pkg::CFG_BITS-1:0]        frame_width,
   input  logic [tlpg_pkg::CFG_BITS-1:0]        frame_height,
   output tlpg_pkg::pix_type                    pix
);

   localparam int DW   = COORD_BITS + 1;
   localparam int EW   = COORD_BITS + 3;
   localparam int MAXA = (COORD_BITS > PEN_BITS + 1) ? COORD_BITS : PEN_BITS + 1;
   localparam int RW   = ((MAXA > tlpg_pkg::CFG_BITS) ? MAXA : tlpg_pkg::CFG_BITS) + 2;

   logic                             active_ff, active_in;
   logic signed [COORD_BITS-1:0]     cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_BITS-1:0]     goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [DW-1:0]             dx_ff, dx_in, dy_ff, dy_in;
   logic                             sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [EW-1:0]             err_ff, err_in;
   logic [PEN_BITS-1:0]              srow_ff, srow_in, scol_ff, scol_in;
   logic [PEN_BITS-1:0]              pen_ff, pen_in;
   logic [tlpg_pkg::COLOR_BITS-1:0]  color_ff, color_in;

   logic [PEN_BITS-1:0]  half, pen_last;
   logic signed [RW-1:0] row_s, col_s;
   logic                 in_frame, pen_zero, col_end, row_end, last_pixel, at_goal;
   logic signed [EW:0]   e2;
   logic                 move_x, move_y;
   logic signed [DW-1:0] dx_raw, dy_raw;

   // Current stamp pixel and clipping
   always_comb begin
      half     = pen_ff >> 1;
      pen_last = pen_ff - PEN_BITS'(1);
      pen_zero = (pen_ff == '0);
      col_end  = (scol_ff == pen_last);
      row_end  = (srow_ff == pen_last);
      row_s = RW'(cur_y_ff) - signed'(RW'(half)) + signed'(RW'(srow_ff));
      col_s = RW'(cur_x_ff) - signed'(RW'(half)) + signed'(RW'(scol_ff));
      in_frame = !row_s[RW-1] && !col_s[RW-1] &&
                 (row_s < signed'(RW'(frame_height))) &&
                 (col_s < signed'(RW'(frame_width)));
      last_pixel = pen_zero || (row_end && col_end);
      at_goal    = (cur_x_ff == goal_x_ff) && (cur_y_ff == goal_y_ff);

      pix.we    = active_ff && !pen_zero && in_frame;
      pix.done  = !active_ff || (last_pixel && at_goal);
      pix.row   = pix.we ? row_s[tlpg_pkg::CFG_BITS-1:0] : '0;
      pix.col   = pix.we ? col_s[tlpg_pkg::CFG_BITS-1:0] : '0;
      pix.color = pix.we ? color_ff : '0;
   end

   // Bresenham error rule, both tests on the old error
   always_comb begin
      e2     = {err_ff, 1'b0};
      move_x = e2 > -(EW + 1)'(dy_ff);
      move_y = e2 < (EW + 1)'(dx_ff);
      dx_raw = DW'(end_x) - DW'(start_x);
      dy_raw = DW'(end_y) - DW'(start_y);
   end

   always_comb begin
      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      err_in    = err_ff;
      srow_in   = srow_ff;
      scol_in   = scol_ff;
      pen_in    = pen_ff;
      color_in  = color_ff;
      if (load) begin
         active_in = 1'b1;
         cur_x_in  = start_x;
         cur_y_in  = start_y;
         goal_x_in = end_x;
         goal_y_in = end_y;
         dx_in     = dx_raw[DW-1] ? -dx_raw : dx_raw;
         dy_in     = dy_raw[DW-1] ? -dy_raw : dy_raw;
         sx_neg_in = !(start_x < end_x);
         sy_neg_in = !(start_y < end_y);
         err_in    = EW'(dx_in) - EW'(dy_in);
         srow_in   = '0;
         scol_in   = '0;
         pen_in    = pen_size;
         color_in  = line_color;
      end else if (step && active_ff) begin
         if (!pen_zero) begin
            scol_in = col_end ? '0 : scol_ff + PEN_BITS'(1);
            srow_in = col_end ? srow_ff + PEN_BITS'(1) : srow_ff;
         end
         if (last_pixel) begin
            srow_in = '0;
            scol_in = '0;
            if (at_goal) begin
               active_in = 1'b0;
            end else begin
               err_in = err_ff - (move_x ? EW'(dy_ff) : EW'(0))
                        + (move_y ? EW'(dx_ff) : EW'(0));
               if (move_x) begin
                  cur_x_in = sx_neg_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
               end
               if (move_y) begin
                  cur_y_in = sy_neg_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      goal_x_ff <= goal_x_in;
      goal_y_ff <= goal_y_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sx_neg_ff <= sx_neg_in;
      sy_neg_ff <= sy_neg_in;
      err_ff    <= err_in;
      srow_ff   <= srow_in;
      scol_ff   <= scol_in;
      pen_ff    <= pen_in;
      color_ff  <= color_in;
   end

endmodule
